@@ rtl/hsv2rgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// shared types and constants for the hsv to rgb color space converter
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // component width, full-scale code means 1.0
  localparam int unsigned COLOR_BITS = 8;
  localparam int unsigned FULL_SCALE = (1 << COLOR_BITS) - 1;

  // hue in sixteenths of a degree
  localparam int unsigned HUE_W      = 13;
  localparam int unsigned HUE_FULL   = 5760;
  localparam int unsigned HUE_SECTOR = 960;
  localparam int unsigned FF_W       = 10;

  // common divisor of all three components: sector width times full scale
  localparam int unsigned DEN   = HUE_SECTOR * FULL_SCALE;
  localparam int unsigned DEN_W = $clog2(DEN + 1);
  localparam int unsigned W_W   = COLOR_BITS + FF_W;
  localparam int unsigned NUM_W = COLOR_BITS + DEN_W;

  // division by the divisor: 960 = 64 * 15 and full scale is odd, so the
  // six low zero bits are shifted out first, then the odd part is divided
  // by a multiply with its rounded-up reciprocal
  localparam int unsigned DIV_SH  = 6;
  localparam int unsigned DIV_ODD = DEN >> DIV_SH;
  localparam int unsigned SH_W    = NUM_W - DIV_SH;
  localparam int unsigned DIV_K   = SH_W + $clog2(DIV_ODD);
  localparam longint unsigned RECIP =
    ((64'd1 << DIV_K) + 64'(DIV_ODD) - 64'd1) / 64'(DIV_ODD);
  localparam int unsigned RECIP_W = $clog2(RECIP + 1);
  localparam int unsigned MUL_W   = SH_W + RECIP_W;

  // lanes of the shared datapath
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned LANE_P    = 0;
  localparam int unsigned LANE_Q    = 1;
  localparam int unsigned LANE_T    = 2;

  // cycles from the accepting edge to the edge that takes the result
  localparam int unsigned LATENCY = 8;

  typedef enum logic [2:0] {
    SECT_RED = 3'd0,
    SECT_YEL = 3'd1,
    SECT_GRN = 3'd2,
    SECT_CYN = 3'd3,
    SECT_BLU = 3'd4,
    SECT_MAG = 3'd5
  } sector_e;

  typedef struct packed {
    logic [HUE_W-1:0]      hue;
    logic [COLOR_BITS-1:0] saturation;
    logic [COLOR_BITS-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } rgb_t;

  // what travels alongside the arithmetic lanes
  typedef struct packed {
    sector_e               sector;
    logic [COLOR_BITS-1:0] value;
  } side_t;

endpackage

@@ rtl/hsv_to_rgb_converter.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// fixed-point hsv to rgb conversion, one pixel per clock, fully pipelined
// ----------------------------------------------------------------------------
// A pixel word is taken at every rising edge where start_i is high; busy_o
// stays low, so a new word may follow in every cycle. The rgb word shows on
// rgb_o with done_o high for exactly one cycle, once it has passed every
// pipeline register, in the order the words came in. The receiver cannot
// stall the block. The pipeline holds one register per stage: input word,
// hue split, saturation weights, complement, value product, rounding offset,
// reciprocal multiply and the output table register.
// Hue codes of 360 degrees and above are taken as hue zero; zero saturation
// gives grey.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  hsv2rgb_pkg::hsv_t  hsv_i,
  output logic               busy_o,
  output logic               done_o,
  output hsv2rgb_pkg::rgb_t  rgb_o
);

  localparam int unsigned CB     = hsv2rgb_pkg::COLOR_BITS;
  localparam int unsigned HUE_W  = hsv2rgb_pkg::HUE_W;
  localparam int unsigned FF_W   = hsv2rgb_pkg::FF_W;
  localparam int unsigned DEN_W  = hsv2rgb_pkg::DEN_W;
  localparam int unsigned W_W    = hsv2rgb_pkg::W_W;
  localparam int unsigned NUM_W  = hsv2rgb_pkg::NUM_W;
  localparam int unsigned NL     = hsv2rgb_pkg::NUM_LANES;
  localparam int unsigned SECT   = hsv2rgb_pkg::HUE_SECTOR;
  localparam int unsigned HALF   = hsv2rgb_pkg::DEN / 2;
  localparam int unsigned SH_W   = hsv2rgb_pkg::SH_W;
  localparam int unsigned MUL_W  = hsv2rgb_pkg::MUL_W;
  localparam int unsigned DIV_SH = hsv2rgb_pkg::DIV_SH;
  localparam int unsigned DIV_K  = hsv2rgb_pkg::DIV_K;

  // the pipeline never backs up, since results cannot be held off
  assign busy_o = 1'b0;

  // --------------------------------------------------------------------------
  // stage 1: input word register
  // --------------------------------------------------------------------------
  logic              in_vld_q;
  hsv2rgb_pkg::hsv_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= hsv_i;
  end

  // --------------------------------------------------------------------------
  // stage 2: hue wrap, sector and fraction within the sector
  // --------------------------------------------------------------------------
  logic [HUE_W-1:0]     hue_wrap;
  logic [HUE_W-1:0]     sect_base;
  hsv2rgb_pkg::sector_e sect_d;
  logic [FF_W-1:0]      ff_d;

  always_comb begin
    hue_wrap = (in_q.hue >= HUE_W'(hsv2rgb_pkg::HUE_FULL)) ? '0 : in_q.hue;
    // compare against the five sector boundaries
    if (hue_wrap >= HUE_W'(5 * SECT)) begin
      sect_d    = hsv2rgb_pkg::SECT_MAG;
      sect_base = HUE_W'(5 * SECT);
    end else if (hue_wrap >= HUE_W'(4 * SECT)) begin
      sect_d    = hsv2rgb_pkg::SECT_BLU;
      sect_base = HUE_W'(4 * SECT);
    end else if (hue_wrap >= HUE_W'(3 * SECT)) begin
      sect_d    = hsv2rgb_pkg::SECT_CYN;
      sect_base = HUE_W'(3 * SECT);
    end else if (hue_wrap >= HUE_W'(2 * SECT)) begin
      sect_d    = hsv2rgb_pkg::SECT_GRN;
      sect_base = HUE_W'(2 * SECT);
    end else if (hue_wrap >= HUE_W'(SECT)) begin
      sect_d    = hsv2rgb_pkg::SECT_YEL;
      sect_base = HUE_W'(SECT);
    end else begin
      sect_d    = hsv2rgb_pkg::SECT_RED;
      sect_base = '0;
    end
    ff_d = FF_W'(hue_wrap - sect_base);
  end

  logic               s2_vld_q;
  hsv2rgb_pkg::side_t s2_side_q;
  logic [FF_W-1:0]    s2_ff_q;
  logic [CB-1:0]      s2_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_side_q.sector <= sect_d;
    s2_side_q.value  <= in_q.brightness;
    s2_ff_q          <= ff_d;
    s2_sat_q         <= in_q.saturation;
  end

  // --------------------------------------------------------------------------
  // stage 3: saturation weights, all scaled to the common divisor
  //   p uses s*960, q uses s*ff, t uses s*(960-ff)
  // --------------------------------------------------------------------------
  logic [W_W-1:0]     w_d [NL];
  logic               s3_vld_q;
  hsv2rgb_pkg::side_t s3_side_q;
  logic [W_W-1:0]     s3_w_q [NL];

  always_comb begin
    w_d[hsv2rgb_pkg::LANE_P] = W_W'(s2_sat_q) * W_W'(SECT);
    w_d[hsv2rgb_pkg::LANE_Q] = W_W'(s2_sat_q) * W_W'(s2_ff_q);
    w_d[hsv2rgb_pkg::LANE_T] = W_W'(s2_sat_q) * (W_W'(SECT) - W_W'(s2_ff_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_side_q <= s2_side_q;
    s3_w_q    <= w_d;
  end

  // --------------------------------------------------------------------------
  // stage 4: complement against the divisor, never negative
  // --------------------------------------------------------------------------
  logic [DEN_W-1:0]   d_d [NL];
  logic               s4_vld_q;
  hsv2rgb_pkg::side_t s4_side_q;
  logic [DEN_W-1:0]   s4_d_q [NL];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      d_d[l] = DEN_W'(hsv2rgb_pkg::DEN) - DEN_W'(s3_w_q[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_side_q <= s3_side_q;
    s4_d_q    <= d_d;
  end

  // --------------------------------------------------------------------------
  // stage 5: scale by the value component
  // --------------------------------------------------------------------------
  logic [NUM_W-1:0]   prod_d [NL];
  logic               s5_vld_q;
  hsv2rgb_pkg::side_t s5_side_q;
  logic [NUM_W-1:0]   s5_prod_q [NL];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      prod_d[l] = NUM_W'(s4_side_q.value) * NUM_W'(s4_d_q[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_side_q <= s4_side_q;
    s5_prod_q <= prod_d;
  end

  // --------------------------------------------------------------------------
  // stage 6: add half the divisor for round half up, then drop the low
  // zero bits of the divisor so only its odd part is left to divide by
  // --------------------------------------------------------------------------
  logic [NUM_W-1:0]   rnd_c [NL];
  logic [SH_W-1:0]    n_d   [NL];
  logic               s6_vld_q;
  hsv2rgb_pkg::side_t s6_side_q;
  logic [SH_W-1:0]    s6_n_q [NL];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      rnd_c[l] = s5_prod_q[l] + NUM_W'(HALF);
      n_d[l]   = SH_W'(rnd_c[l] >> DIV_SH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_side_q <= s5_side_q;
    s6_n_q    <= n_d;
  end

  // --------------------------------------------------------------------------
  // stage 7: divide by the odd part with its rounded-up reciprocal; the
  // error stays below one quotient step over the whole dividend range, and
  // the quotient never exceeds the value component, so CB bits suffice
  // --------------------------------------------------------------------------
  logic [MUL_W-1:0]   mul_c [NL];
  logic [CB-1:0]      quo_d [NL];
  logic               s7_vld_q;
  hsv2rgb_pkg::side_t s7_side_q;
  logic [CB-1:0]      s7_quo_q [NL];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      mul_c[l] = MUL_W'(s6_n_q[l]) * MUL_W'(hsv2rgb_pkg::RECIP);
      quo_d[l] = CB'(mul_c[l] >> DIV_K);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else begin
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_side_q <= s6_side_q;
    s7_quo_q  <= quo_d;
  end

  // --------------------------------------------------------------------------
  // output: sector table picks r, g, b from v, p, q, t
  // --------------------------------------------------------------------------
  logic [CB-1:0]     v_c;
  logic [CB-1:0]     p_c;
  logic [CB-1:0]     q_c;
  logic [CB-1:0]     t_c;
  hsv2rgb_pkg::rgb_t rgb_d;
  logic              done_q;
  hsv2rgb_pkg::rgb_t rgb_q;

  assign v_c = s7_side_q.value;
  assign p_c = s7_quo_q[hsv2rgb_pkg::LANE_P];
  assign q_c = s7_quo_q[hsv2rgb_pkg::LANE_Q];
  assign t_c = s7_quo_q[hsv2rgb_pkg::LANE_T];

  always_comb begin
    case (s7_side_q.sector)
      hsv2rgb_pkg::SECT_RED: begin
        rgb_d = '{red: v_c, green: t_c, blue: p_c};
      end
      hsv2rgb_pkg::SECT_YEL: begin
        rgb_d = '{red: q_c, green: v_c, blue: p_c};
      end
      hsv2rgb_pkg::SECT_GRN: begin
        rgb_d = '{red: p_c, green: v_c, blue: t_c};
      end
      hsv2rgb_pkg::SECT_CYN: begin
        rgb_d = '{red: p_c, green: q_c, blue: v_c};
      end
      hsv2rgb_pkg::SECT_BLU: begin
        rgb_d = '{red: t_c, green: p_c, blue: v_c};
      end
      default: begin
        rgb_d = '{red: v_c, green: p_c, blue: q_c};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s7_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rgb_q <= rgb_d;
  end

  assign done_o = done_q;
  assign rgb_o  = rgb_q;

endmodule

@@ rtl/hsv2rgb_checker.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// port-level checks of the hsv to rgb converter, bound to the top level
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input hsv2rgb_pkg::hsv_t hsv_i,
  input logic              busy_o,
  input logic              done_o,
  input hsv2rgb_pkg::rgb_t rgb_o
);

  localparam int unsigned LAT = hsv2rgb_pkg::LATENCY;

  logic acc;
  assign acc = start_i & ~busy_o;

  // every accepted word comes out after the fixed latency
  a_word_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##LAT done_o)
    else $error("accepted word did not come out");

  // no result without a word accepted the latency before
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc, LAT))
    else $error("result without an accepted word");

  // zero saturation gives grey at the value level
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && hsv_i.saturation == '0) |-> ##LAT
      (rgb_o.red == $past(hsv_i.brightness, LAT) &&
       rgb_o.green == $past(hsv_i.brightness, LAT) &&
       rgb_o.blue == $past(hsv_i.brightness, LAT)))
    else $error("zero saturation did not give grey");

  // the largest component equals the value component
  a_max_is_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##LAT
      (rgb_o.red <= $past(hsv_i.brightness, LAT) &&
       rgb_o.green <= $past(hsv_i.brightness, LAT) &&
       rgb_o.blue <= $past(hsv_i.brightness, LAT) &&
       (rgb_o.red == $past(hsv_i.brightness, LAT) ||
        rgb_o.green == $past(hsv_i.brightness, LAT) ||
        rgb_o.blue == $past(hsv_i.brightness, LAT))))
    else $error("largest component differs from value");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_checker (.*);

@@ tb/sv/hsv_to_rgb_converter_tb.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_tb
// self-checking bench for the hsv to rgb color space converter
// ----------------------------------------------------------------------------
// Pixel words go in as a short hand-written table (corners, sector edges,
// grey and out-of-range hues), then as a random stream in bursts with gaps.
// Every accepted word gets its expected rgb word from its table row where
// the row gives one, else from a local integer model of the conversion;
// the rgb words coming out are checked in order, field by field.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_tb;

  localparam int unsigned CB          = hsv2rgb_pkg::COLOR_BITS;
  localparam int unsigned HUE_W       = hsv2rgb_pkg::HUE_W;
  localparam int unsigned HUE_FULL    = hsv2rgb_pkg::HUE_FULL;
  localparam int unsigned HUE_SECTOR  = hsv2rgb_pkg::HUE_SECTOR;
  localparam int unsigned FULL_SCALE  = hsv2rgb_pkg::FULL_SCALE;
  localparam int unsigned LATENCY     = hsv2rgb_pkg::LATENCY;
  localparam int unsigned N_RANDOM    = 650;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned N_TABLE     = 23;

  // one table row: pixel word, then the rgb word when it is obvious
  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CB-1:0]    sat;
    logic [CB-1:0]    val;
    bit               known;
    logic [CB-1:0]    red;
    logic [CB-1:0]    green;
    logic [CB-1:0]    blue;
  } pixel_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  hsv2rgb_pkg::hsv_t  hsv_i;
  logic               busy_o;
  logic               done_o;
  hsv2rgb_pkg::rgb_t  rgb_o;

  // rgb words still owed by the block, oldest first
  hsv2rgb_pkg::rgb_t  rgb_owed_q[$];

  int unsigned cycle_cnt;
  int unsigned err_cnt;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned wrapped_hues;
  int unsigned grey_words;

  // corners, the six sector starts at full saturation and value, grey,
  // hues at and beyond 360 degrees, and a few mid-range points
  pixel_row_t pixel_tab [N_TABLE] = '{
    '{13'd0,    8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0  },
    '{13'd0,    8'd0,   8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
    '{13'd3000, 8'd0,   8'd128, 1'b1, 8'd128, 8'd128, 8'd128},
    '{13'd8191, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0  },
    '{13'd5760, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0  },
    '{13'd0,    8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0  },
    '{13'd960,  8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd0  },
    '{13'd1920, 8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd0  },
    '{13'd2880, 8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd255},
    '{13'd3840, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd255},
    '{13'd4800, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd255},
    '{13'd7000, 8'd255, 8'd0,   1'b1, 8'd0,   8'd0,   8'd0  },
    '{13'd5759, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0  },
    '{13'd959,  8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0  },
    '{13'd480,  8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0  },
    '{13'd1440, 8'd128, 8'd200, 1'b0, 8'd0,   8'd0,   8'd0  },
    '{13'd2400, 8'd1,   8'd254, 1'b0, 8'd0,   8'd0,   8'd0  },
    '{13'd3360, 8'd254, 8'd1,   1'b0, 8'd0,   8'd0,   8'd0  },
    '{13'd4320, 8'd170, 8'd85,  1'b0, 8'd0,   8'd0,   8'd0  },
    '{13'd5280, 8'd85,  8'd170, 1'b0, 8'd0,   8'd0,   8'd0  },
    '{13'd4095, 8'd100, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0  },
    '{13'd6000, 8'd17,  8'd99,  1'b0, 8'd0,   8'd0,   8'd0  },
    '{13'd1000, 8'd255, 8'd128, 1'b0, 8'd0,   8'd0,   8'd0  }
  };

  hsv_to_rgb_converter u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .hsv_i   (hsv_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .rgb_o   (rgb_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // integer hsv to rgb: q and t share the rounding divisor
  // sector width times full scale, p uses full scale alone
  function automatic hsv2rgb_pkg::rgb_t hsv_to_rgb(hsv2rgb_pkg::hsv_t px);
    logic [63:0]          m;
    logic [63:0]          h;
    logic [63:0]          s;
    logic [63:0]          v;
    logic [63:0]          ff;
    logic [63:0]          den;
    logic [63:0]          p;
    logic [63:0]          q;
    logic [63:0]          t;
    logic [63:0]          sect_idx;
    logic [63:0]          sect_w;
    hsv2rgb_pkg::sector_e sect;
    hsv2rgb_pkg::rgb_t    rgb;
    m      = 64'(FULL_SCALE);
    sect_w = 64'(HUE_SECTOR);
    h      = 64'(px.hue);
    s      = 64'(px.saturation);
    v      = 64'(px.brightness);
    // hues of 360 degrees and up wrap to zero
    if (h >= 64'(HUE_FULL)) begin
      h = '0;
    end
    sect_idx = h / sect_w;
    sect     = hsv2rgb_pkg::sector_e'(sect_idx[2:0]);
    ff       = h % sect_w;
    den      = m * sect_w;
    // round half up on every quotient
    p = (v * (m - s) + m / 64'd2) / m;
    q = (v * (den - s * ff) + den / 64'd2) / den;
    t = (v * (den - s * (sect_w - ff)) + den / 64'd2) / den;
    case (sect)
      hsv2rgb_pkg::SECT_RED: begin
        rgb.red = v[CB-1:0]; rgb.green = t[CB-1:0]; rgb.blue = p[CB-1:0];
      end
      hsv2rgb_pkg::SECT_YEL: begin
        rgb.red = q[CB-1:0]; rgb.green = v[CB-1:0]; rgb.blue = p[CB-1:0];
      end
      hsv2rgb_pkg::SECT_GRN: begin
        rgb.red = p[CB-1:0]; rgb.green = v[CB-1:0]; rgb.blue = t[CB-1:0];
      end
      hsv2rgb_pkg::SECT_CYN: begin
        rgb.red = p[CB-1:0]; rgb.green = q[CB-1:0]; rgb.blue = v[CB-1:0];
      end
      hsv2rgb_pkg::SECT_BLU: begin
        rgb.red = t[CB-1:0]; rgb.green = p[CB-1:0]; rgb.blue = v[CB-1:0];
      end
      default: begin
        rgb.red = v[CB-1:0]; rgb.green = p[CB-1:0]; rgb.blue = q[CB-1:0];
      end
    endcase
    return rgb;
  endfunction

  // present one pixel word from the falling edge on, hold it until a rising
  // edge takes it, then log what the block now owes
  task automatic send_pixel(hsv2rgb_pkg::hsv_t px, bit known,
                            hsv2rgb_pkg::rgb_t known_rgb);
    @(negedge clk_i);
    start_i <= 1'b1;
    hsv_i   <= px;
    do begin
      @(posedge clk_i);
    end while (busy_o);
    rgb_owed_q.push_back(known ? known_rgb : hsv_to_rgb(px));
    words_sent++;
    if (px.hue >= HUE_FULL) begin
      wrapped_hues++;
    end
    if (px.saturation == '0) begin
      grey_words++;
    end
  endtask

  // idle cycles with junk on the data lines
  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      hsv_i   <= hsv2rgb_pkg::hsv_t'($urandom);
    end
  endtask

  // hold off until the block has returned every word it owes
  task automatic drain_owed();
    idle_cycles(1);
    while (rgb_owed_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // saturation or value: the extremes come up often
  function automatic logic [CB-1:0] pick_level();
    logic [CB-1:0] lvl;
    case ($urandom_range(0, 9))
      0:       lvl = '0;
      1:       lvl = '1;
      2:       lvl = CB'($urandom_range(0, 1) ? 1 : FULL_SCALE - 1);
      default: lvl = CB'($urandom_range(0, FULL_SCALE));
    endcase
    return lvl;
  endfunction

  // hue: mostly in range, some wrapped, some right on a sector edge
  function automatic logic [HUE_W-1:0] pick_hue();
    int hue;
    case ($urandom_range(0, 9))
      0: hue = $urandom_range(HUE_FULL, (1 << HUE_W) - 1);
      1: begin
        hue = $urandom_range(0, 6) * HUE_SECTOR + $urandom_range(0, 2) - 1;
        if (hue < 0) begin
          hue = 0;
        end
      end
      default: hue = $urandom_range(0, HUE_FULL - 1);
    endcase
    return HUE_W'(hue);
  endfunction

  // rgb checker: every done_o pulse must match the oldest owed word
  always @(posedge clk_i) begin
    hsv2rgb_pkg::rgb_t owed;
    if (rst_ni && done_o) begin
      if (rgb_owed_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
          $display("[%0t] unexpected rgb word r=%0d g=%0d b=%0d", $realtime,
                   rgb_o.red, rgb_o.green, rgb_o.blue);
        end
      end else begin
        owed = rgb_owed_q.pop_front();
        words_checked++;
        if (rgb_o.red !== owed.red || rgb_o.green !== owed.green ||
            rgb_o.blue !== owed.blue) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("[%0t] rgb mismatch: exp r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     $realtime, owed.red, owed.green, owed.blue,
                     rgb_o.red, rgb_o.green, rgb_o.blue);
          end
        end
      end
    end
  end

  // watchdog against a hung block
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed", cycle_cnt,
               rgb_owed_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    hsv2rgb_pkg::hsv_t px;
    hsv2rgb_pkg::rgb_t known_rgb;
    int unsigned       burst;
    int unsigned       sent;
    // known inputs from time zero, reset held low before release
    cycle_cnt     = 0;
    err_cnt       = 0;
    words_sent    = 0;
    words_checked = 0;
    wrapped_hues  = 0;
    grey_words    = 0;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    hsv_i         = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table, words back to back with the odd gap
    foreach (pixel_tab[i]) begin
      px.hue        = pixel_tab[i].hue;
      px.saturation = pixel_tab[i].sat;
      px.brightness = pixel_tab[i].val;
      known_rgb     = '{red: pixel_tab[i].red, green: pixel_tab[i].green,
                        blue: pixel_tab[i].blue};
      send_pixel(px, pixel_tab[i].known, known_rgb);
      if (i % 5 == 4) begin
        idle_cycles($urandom_range(1, 3));
      end
    end
    drain_owed();

    // random stream: bursts of random length with random gaps, some long
    // runs with no gap at all, and one full drain half way through
    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 12);
      repeat (burst) begin
        if (sent < N_RANDOM) begin
          px.hue        = pick_hue();
          px.saturation = pick_level();
          px.brightness = pick_level();
          send_pixel(px, 1'b0, '0);
          sent++;
          if (sent == N_RANDOM / 2) begin
            drain_owed();
          end
        end
      end
      case ($urandom_range(0, 7))
        0, 1:    ;
        2:       idle_cycles($urandom_range(LATENCY, 3 * LATENCY));
        default: idle_cycles($urandom_range(1, 6));
      endcase
    end

    // wait out the pipeline, then a few cycles for any stray done_o
    drain_owed();
    repeat (LATENCY + 8) @(posedge clk_i);

    $display("sent %0d pixel words (%0d wrapped hues, %0d grey), checked %0d rgb words",
             words_sent, wrapped_hues, grey_words, words_checked);
    $display("%0d failures seen over %0d cycles", err_cnt, cycle_cnt);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
